// ===== src/pptc_pkg.sv =====
// ----------------------------------------------------------------------------
// pptc_pkg
// Shared sizes and record codes for the per-protocol traffic counter table.
// ----------------------------------------------------------------------------
package pptc_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic CMD_COUNTERS = 1'b0;
    localparam logic CMD_PROTOCOL = 1'b1;

endpackage

// ===== src/per_protocol_traffic_counter_table.sv =====
// Throughput: one item at a time; the linear key search reads one slot a cycle
// from the key memory, then the totals memory is read, summed and written back.
// The next item is accepted while a finished result waits at the output register.
// Reset clears the slot count, maxima and stamps; memory contents are not cleared.
// ----------------------------------------------------------------------------
// per_protocol_traffic_counter_table
// Per-ethertype byte and packet totals kept in a searched table, plus running
// counters maxima, first counters stamp, and last stamp except on table-full.
// ----------------------------------------------------------------------------
module per_protocol_traffic_counter_table
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [63:0] timestamp,
    input  logic [15:0] ethertype,
    input  logic [31:0] byte_delta,
    input  logic [31:0] packet_delta,
    input  logic [31:0] block_count,
    input  logic [31:0] byte_count,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  entry_index,
    output logic        is_new_entry,
    output logic        table_full,
    output logic [31:0] entry_bytes,
    output logic [31:0] entry_packets,
    output logic [8:0]  entries_used,
    output logic [31:0] max_blocks,
    output logic [31:0] max_bytes,
    output logic [63:0] first_time,
    output logic [63:0] last_time
);

    localparam int IDX_W = pptc_pkg::IDX_W;
    localparam int CNT_W = pptc_pkg::CNT_W;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_COUNTERS,
        ST_SCAN,
        ST_MISS,
        ST_HIT_RD,
        ST_HIT_WR
    } state_t;

    state_t state_reg, state_next;

    // item holding registers
    logic [63:0] stamp_reg, stamp_next;
    logic [15:0] key_reg, key_next;
    logic [31:0] dbytes_reg, dbytes_next;
    logic [31:0] dpackets_reg, dpackets_next;
    logic [31:0] blocks_reg, blocks_next;
    logic [31:0] bytes_reg, bytes_next;

    // search control
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             chk_last_reg, chk_last_next;
    logic [IDX_W-1:0] slot_reg, slot_next;

    // block state
    logic [CNT_W-1:0] used_reg, used_next;
    logic [31:0]      peak_blocks_reg, peak_blocks_next;
    logic [31:0]      peak_bytes_reg, peak_bytes_next;
    logic             started_reg, started_next;
    logic [63:0]      start_stamp_reg, start_stamp_next;
    logic [63:0]      end_stamp_reg, end_stamp_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_index_reg, out_index_next;
    logic        out_new_reg, out_new_next;
    logic        out_full_reg, out_full_next;
    logic [31:0] out_bytes_reg, out_bytes_next;
    logic [31:0] out_packets_reg, out_packets_next;
    logic [8:0]  out_used_reg, out_used_next;
    logic [31:0] out_max_blocks_reg, out_max_blocks_next;
    logic [31:0] out_max_bytes_reg, out_max_bytes_next;
    logic [63:0] out_first_reg, out_first_next;
    logic [63:0] out_last_reg, out_last_next;

    // memories
    logic [15:0] key_mem [pptc_pkg::TABLE_ENTRIES];
    logic [63:0] tot_mem [pptc_pkg::TABLE_ENTRIES];
    logic [15:0] key_rdata;
    logic [63:0] tot_rdata;
    logic        mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [15:0] key_wdata;
    logic [63:0] tot_wdata;
    logic        key_we;

    logic             out_free;
    logic             load;
    logic [IDX_W+7:0] slot_ext;
    logic [CNT_W+8:0] used_ext;
    logic [31:0]      sum_bytes;
    logic [31:0]      sum_packets;

    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign sum_bytes = tot_rdata[63:32] + dbytes_reg;
    assign sum_packets = tot_rdata[31:0] + dpackets_reg;

    always_ff @(posedge clk)
    begin
        key_rdata <= key_mem[issue_reg[IDX_W-1:0]];
        tot_rdata <= tot_mem[slot_reg];
        if (key_we)
        begin
            key_mem[mem_waddr] <= key_wdata;
        end
        if (mem_we)
        begin
            tot_mem[mem_waddr] <= tot_wdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        stamp_next = stamp_reg;
        key_next = key_reg;
        dbytes_next = dbytes_reg;
        dpackets_next = dpackets_reg;
        blocks_next = blocks_reg;
        bytes_next = bytes_reg;
        issue_next = issue_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next = chk_idx_reg;
        chk_last_next = chk_last_reg;
        slot_next = slot_reg;
        used_next = used_reg;
        peak_blocks_next = peak_blocks_reg;
        peak_bytes_next = peak_bytes_reg;
        started_next = started_reg;
        start_stamp_next = start_stamp_reg;
        end_stamp_next = end_stamp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_index_next = out_index_reg;
        out_new_next = out_new_reg;
        out_full_next = out_full_reg;
        out_bytes_next = out_bytes_reg;
        out_packets_next = out_packets_reg;
        out_used_next = out_used_reg;
        out_max_blocks_next = out_max_blocks_reg;
        out_max_bytes_next = out_max_bytes_reg;
        out_first_next = out_first_reg;
        out_last_next = out_last_reg;
        mem_we = 1'b0;
        key_we = 1'b0;
        mem_waddr = used_reg[IDX_W-1:0];
        key_wdata = key_reg;
        tot_wdata = {dbytes_reg, dpackets_reg};
        load = 1'b0;
        slot_ext = '0;
        used_ext = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    stamp_next = timestamp;
                    key_next = ethertype;
                    dbytes_next = byte_delta;
                    dpackets_next = packet_delta;
                    blocks_next = block_count;
                    bytes_next = byte_count;
                    issue_next = '0;
                    chk_valid_next = 1'b0;
                    if (command == pptc_pkg::CMD_COUNTERS)
                    begin
                        state_next = ST_COUNTERS;
                    end
                    else if (used_reg == '0)
                    begin
                        state_next = ST_MISS;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_COUNTERS:
            begin
                if (out_free)
                begin
                    if (blocks_reg > peak_blocks_reg)
                    begin
                        peak_blocks_next = blocks_reg;
                    end
                    if (bytes_reg > peak_bytes_reg)
                    begin
                        peak_bytes_next = bytes_reg;
                    end
                    if (!started_reg)
                    begin
                        start_stamp_next = stamp_reg;
                        started_next = 1'b1;
                    end
                    end_stamp_next = stamp_reg;
                    out_index_next = '0;
                    out_new_next = 1'b0;
                    out_full_next = 1'b0;
                    out_bytes_next = '0;
                    out_packets_next = '0;
                    load = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                // issue the next slot read while checking the previous one
                if (issue_reg < used_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next = issue_reg[IDX_W-1:0];
                    chk_last_next = ((issue_reg + CNT_W'(1)) == used_reg);
                    issue_next = issue_reg + CNT_W'(1);
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
                if (chk_valid_reg)
                begin
                    if (key_rdata == key_reg)
                    begin
                        slot_next = chk_idx_reg;
                        state_next = ST_HIT_RD;
                    end
                    else if (chk_last_reg)
                    begin
                        state_next = ST_MISS;
                    end
                end
            end

            ST_HIT_RD:
            begin
                state_next = ST_HIT_WR;
            end

            ST_HIT_WR:
            begin
                if (out_free)
                begin
                    mem_we = 1'b1;
                    mem_waddr = slot_reg;
                    tot_wdata = {sum_bytes, sum_packets};
                    end_stamp_next = stamp_reg;
                    slot_ext = {8'd0, slot_reg};
                    out_index_next = slot_ext[7:0];
                    out_new_next = 1'b0;
                    out_full_next = 1'b0;
                    out_bytes_next = sum_bytes;
                    out_packets_next = sum_packets;
                    load = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_MISS:
            begin
                if (out_free)
                begin
                    if (used_reg >= CNT_W'(pptc_pkg::TABLE_ENTRIES))
                    begin
                        out_index_next = '0;
                        out_new_next = 1'b0;
                        out_full_next = 1'b1;
                        out_bytes_next = '0;
                        out_packets_next = '0;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        key_we = 1'b1;
                        used_next = used_reg + CNT_W'(1);
                        end_stamp_next = stamp_reg;
                        slot_ext = {8'd0, used_reg[IDX_W-1:0]};
                        out_index_next = slot_ext[7:0];
                        out_new_next = 1'b1;
                        out_full_next = 1'b0;
                        out_bytes_next = dbytes_reg;
                        out_packets_next = dpackets_reg;
                    end
                    load = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            used_ext = {9'd0, used_next};
            out_valid_next = 1'b1;
            out_used_next = used_ext[8:0];
            out_max_blocks_next = peak_blocks_next;
            out_max_bytes_next = peak_bytes_next;
            out_first_next = start_stamp_next;
            out_last_next = end_stamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stamp_reg <= '0;
            key_reg <= '0;
            dbytes_reg <= '0;
            dpackets_reg <= '0;
            blocks_reg <= '0;
            bytes_reg <= '0;
            issue_reg <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg <= '0;
            chk_last_reg <= 1'b0;
            slot_reg <= '0;
            used_reg <= '0;
            peak_blocks_reg <= '0;
            peak_bytes_reg <= '0;
            started_reg <= 1'b0;
            start_stamp_reg <= '0;
            end_stamp_reg <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_new_reg <= 1'b0;
            out_full_reg <= 1'b0;
            out_bytes_reg <= '0;
            out_packets_reg <= '0;
            out_used_reg <= '0;
            out_max_blocks_reg <= '0;
            out_max_bytes_reg <= '0;
            out_first_reg <= '0;
            out_last_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stamp_reg <= stamp_next;
            key_reg <= key_next;
            dbytes_reg <= dbytes_next;
            dpackets_reg <= dpackets_next;
            blocks_reg <= blocks_next;
            bytes_reg <= bytes_next;
            issue_reg <= issue_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg <= chk_idx_next;
            chk_last_reg <= chk_last_next;
            slot_reg <= slot_next;
            used_reg <= used_next;
            peak_blocks_reg <= peak_blocks_next;
            peak_bytes_reg <= peak_bytes_next;
            started_reg <= started_next;
            start_stamp_reg <= start_stamp_next;
            end_stamp_reg <= end_stamp_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_new_reg <= out_new_next;
            out_full_reg <= out_full_next;
            out_bytes_reg <= out_bytes_next;
            out_packets_reg <= out_packets_next;
            out_used_reg <= out_used_next;
            out_max_blocks_reg <= out_max_blocks_next;
            out_max_bytes_reg <= out_max_bytes_next;
            out_first_reg <= out_first_next;
            out_last_reg <= out_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign entry_index = out_index_reg;
    assign is_new_entry = out_new_reg;
    assign table_full = out_full_reg;
    assign entry_bytes = out_bytes_reg;
    assign entry_packets = out_packets_reg;
    assign entries_used = out_used_reg;
    assign max_blocks = out_max_blocks_reg;
    assign max_bytes = out_max_bytes_reg;
    assign first_time = out_first_reg;
    assign last_time = out_last_reg;

endmodule

// ===== verif/per_protocol_traffic_counter_table_monitor.sv =====
// ----------------------------------------------------------------------------
// per_protocol_traffic_counter_table_monitor
// Watches both channels of the traffic counter table, keeps its own copy of
// the ethertype table, maxima and stamps, and compares every result item
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module per_protocol_traffic_counter_table_monitor
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        command,
    input  logic [63:0] timestamp,
    input  logic [15:0] ethertype,
    input  logic [31:0] byte_delta,
    input  logic [31:0] packet_delta,
    input  logic [31:0] block_count,
    input  logic [31:0] byte_count,

    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  entry_index,
    input  logic        is_new_entry,
    input  logic        table_full,
    input  logic [31:0] entry_bytes,
    input  logic [31:0] entry_packets,
    input  logic [8:0]  entries_used,
    input  logic [31:0] max_blocks,
    input  logic [31:0] max_bytes,
    input  logic [63:0] first_time,
    input  logic [63:0] last_time,

    output int          mismatch_count,
    output int          pending_results
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [7:0]  entry_index;
        logic        is_new_entry;
        logic        table_full;
        logic [31:0] entry_bytes;
        logic [31:0] entry_packets;
        logic [8:0]  entries_used;
        logic [31:0] max_blocks;
        logic [31:0] max_bytes;
        logic [63:0] first_time;
        logic [63:0] last_time;
    } traffic_result_t;

    logic [15:0]     slot_keys [pptc_pkg::TABLE_ENTRIES];
    logic [31:0]     slot_bytes [pptc_pkg::TABLE_ENTRIES];
    logic [31:0]     slot_packets [pptc_pkg::TABLE_ENTRIES];
    int              slots_used;
    logic [31:0]     peak_blocks;
    logic [31:0]     peak_bytes;
    logic            seen_counters;
    logic [63:0]     first_stamp;
    logic [63:0]     latest_stamp;
    traffic_result_t expected_results [$];
    int              result_number;

    function automatic traffic_result_t tally_record(input logic cmd,
                                                     input logic [63:0] stamp,
                                                     input logic [15:0] key,
                                                     input logic [31:0] add_bytes,
                                                     input logic [31:0] add_packets,
                                                     input logic [31:0] blocks,
                                                     input logic [31:0] bytes_rx);
        traffic_result_t r;
        logic            hit;
        int              slot;
        r = '0;
        hit = 1'b0;
        slot = 0;
        if (cmd == pptc_pkg::CMD_COUNTERS)
        begin
            if (blocks > peak_blocks)
                peak_blocks = blocks;
            if (bytes_rx > peak_bytes)
                peak_bytes = bytes_rx;
            if (!seen_counters)
            begin
                first_stamp = stamp;
                seen_counters = 1'b1;
            end
            latest_stamp = stamp;
        end
        else
        begin
            for (int i = 0; i < pptc_pkg::TABLE_ENTRIES; i++)
            begin
                if (!hit && i < slots_used && slot_keys[i] == key)
                begin
                    hit = 1'b1;
                    slot = i;
                end
            end
            if (hit)
            begin
                latest_stamp = stamp;
                slot_bytes[slot] = slot_bytes[slot] + add_bytes;
                slot_packets[slot] = slot_packets[slot] + add_packets;
            end
            else if (slots_used < pptc_pkg::TABLE_ENTRIES)
            begin
                latest_stamp = stamp;
                slot = slots_used;
                slot_keys[slot] = key;
                slot_bytes[slot] = add_bytes;
                slot_packets[slot] = add_packets;
                slots_used++;
                r.is_new_entry = 1'b1;
            end
            if (hit || r.is_new_entry)
            begin
                r.entry_index = slot[7:0];
                r.entry_bytes = slot_bytes[slot];
                r.entry_packets = slot_packets[slot];
            end
            else
                r.table_full = 1'b1;
        end
        r.entries_used = slots_used[8:0];
        r.max_blocks = peak_blocks;
        r.max_bytes = peak_bytes;
        r.first_time = first_stamp;
        r.last_time = latest_stamp;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("ERROR result %0d: %s", result_number, msg);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        traffic_result_t seen;
        traffic_result_t want;
        if (!rst_n)
        begin
            slots_used = 0;
            peak_blocks = '0;
            peak_bytes = '0;
            seen_counters = 1'b0;
            first_stamp = '0;
            latest_stamp = '0;
            expected_results.delete();
            result_number = 0;
            mismatch_count = 0;
            pending_results = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {entry_index, is_new_entry, table_full, entry_bytes, entry_packets,
                        entries_used, max_blocks, max_bytes, first_time, last_time};
                if (expected_results.size() == 0)
                    report_mismatch("result item with none expected");
                else
                begin
                    want = expected_results.pop_front();
                    if (seen.entry_index !== want.entry_index)
                        report_mismatch($sformatf("entry_index got %h want %h",
                                                  seen.entry_index, want.entry_index));
                    if (seen.is_new_entry !== want.is_new_entry)
                        report_mismatch($sformatf("is_new_entry got %b want %b",
                                                  seen.is_new_entry, want.is_new_entry));
                    if (seen.table_full !== want.table_full)
                        report_mismatch($sformatf("table_full got %b want %b",
                                                  seen.table_full, want.table_full));
                    if (seen.entry_bytes !== want.entry_bytes)
                        report_mismatch($sformatf("entry_bytes got %h want %h",
                                                  seen.entry_bytes, want.entry_bytes));
                    if (seen.entry_packets !== want.entry_packets)
                        report_mismatch($sformatf("entry_packets got %h want %h",
                                                  seen.entry_packets, want.entry_packets));
                    if (seen.entries_used !== want.entries_used)
                        report_mismatch($sformatf("entries_used got %h want %h",
                                                  seen.entries_used, want.entries_used));
                    if (seen.max_blocks !== want.max_blocks)
                        report_mismatch($sformatf("max_blocks got %h want %h",
                                                  seen.max_blocks, want.max_blocks));
                    if (seen.max_bytes !== want.max_bytes)
                        report_mismatch($sformatf("max_bytes got %h want %h",
                                                  seen.max_bytes, want.max_bytes));
                    if (seen.first_time !== want.first_time)
                        report_mismatch($sformatf("first_time got %h want %h",
                                                  seen.first_time, want.first_time));
                    if (seen.last_time !== want.last_time)
                        report_mismatch($sformatf("last_time got %h want %h",
                                                  seen.last_time, want.last_time));
                end
                result_number++;
            end
            if (in_valid && !in_stall)
                expected_results.push_back(tally_record(command, timestamp, ethertype,
                                                        byte_delta, packet_delta,
                                                        block_count, byte_count));
            pending_results = expected_results.size();
        end
    end

endmodule

// ===== verif/per_protocol_traffic_counter_table_test.sv =====
// ----------------------------------------------------------------------------
// per_protocol_traffic_counter_table_test
// Drives directed and random monitoring records into the traffic counter
// table with bursty input and a stalling receiver, fills the table past its
// capacity, and reports the verdict from the monitor's mismatch count.
// ----------------------------------------------------------------------------
module per_protocol_traffic_counter_table_test;

    localparam int RECORD_COUNT  = 1100;
    localparam int SETTLE_CYCLES = pptc_pkg::TABLE_ENTRIES + 40;
    localparam int DRAIN_EVERY   = 350;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = pptc_pkg::CMD_COUNTERS;
    logic [63:0] timestamp = '0;
    logic [15:0] ethertype = '0;
    logic [31:0] byte_delta = '0;
    logic [31:0] packet_delta = '0;
    logic [31:0] block_count = '0;
    logic [31:0] byte_count = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  entry_index;
    logic        is_new_entry;
    logic        table_full;
    logic [31:0] entry_bytes;
    logic [31:0] entry_packets;
    logic [8:0]  entries_used;
    logic [31:0] max_blocks;
    logic [31:0] max_bytes;
    logic [63:0] first_time;
    logic [63:0] last_time;

    int          mismatch_count;
    int          pending_results;
    logic        draining = 1'b0;
    logic [15:0] key_pool [$];

    per_protocol_traffic_counter_table i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .timestamp     (timestamp),
        .ethertype     (ethertype),
        .byte_delta    (byte_delta),
        .packet_delta  (packet_delta),
        .block_count   (block_count),
        .byte_count    (byte_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .entry_index   (entry_index),
        .is_new_entry  (is_new_entry),
        .table_full    (table_full),
        .entry_bytes   (entry_bytes),
        .entry_packets (entry_packets),
        .entries_used  (entries_used),
        .max_blocks    (max_blocks),
        .max_bytes     (max_bytes),
        .first_time    (first_time),
        .last_time     (last_time)
    );

    per_protocol_traffic_counter_table_monitor i_monitor
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .timestamp       (timestamp),
        .ethertype       (ethertype),
        .byte_delta      (byte_delta),
        .packet_delta    (packet_delta),
        .block_count     (block_count),
        .byte_count      (byte_count),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .entry_index     (entry_index),
        .is_new_entry    (is_new_entry),
        .table_full      (table_full),
        .entry_bytes     (entry_bytes),
        .entry_packets   (entry_packets),
        .entries_used    (entries_used),
        .max_blocks      (max_blocks),
        .max_bytes       (max_bytes),
        .first_time      (first_time),
        .last_time       (last_time),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #15000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stall_pattern
        int mode;
        int span;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 400);
            for (int n = 0; n < span; n++)
            begin
                @(negedge clk);
                if (draining)
                    out_stall <= 1'b0;
                else
                begin
                    unique case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= ((n % 16) < 9);
                    endcase
                end
            end
        end
    end

    task automatic send_record(input logic cmd, input logic [63:0] stamp,
                               input logic [15:0] key, input logic [31:0] add_bytes,
                               input logic [31:0] add_packets, input logic [31:0] blocks,
                               input logic [31:0] bytes_rx);
        @(negedge clk);
        command <= cmd;
        timestamp <= stamp;
        ethertype <= key;
        byte_delta <= add_bytes;
        packet_delta <= add_packets;
        block_count <= blocks;
        byte_count <= bytes_rx;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
    endtask

    function automatic logic [31:0] wide_or_small();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 4095);
    endfunction

    initial
    begin : stimulus
        int          sent;
        int          burst;
        logic        cmd;
        logic [15:0] key;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_record(pptc_pkg::CMD_PROTOCOL, 64'h0, 16'h0000, 32'h0, 32'h0, $urandom,
                    $urandom);
        send_record(pptc_pkg::CMD_PROTOCOL, '1, 16'hFFFF, '1, '1, '1, '1);
        send_record(pptc_pkg::CMD_PROTOCOL, 64'h1, 16'hFFFF, 32'h1, 32'h2, 32'h0, 32'h0);
        send_record(pptc_pkg::CMD_COUNTERS, 64'h0123_4567_89AB_CDEF, 16'($urandom),
                    $urandom, $urandom, 32'h0, 32'h0);
        send_record(pptc_pkg::CMD_COUNTERS, 64'h2, 16'h0, 32'h0, 32'h0, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF);
        send_record(pptc_pkg::CMD_COUNTERS, 64'h3, 16'h0, 32'h0, 32'h0, 32'h8000_0000,
                    32'h8000_0000);
        send_record(pptc_pkg::CMD_COUNTERS, 64'h4, 16'h0, 32'h0, 32'h0, 32'h1, 32'h1);
        send_record(pptc_pkg::CMD_COUNTERS, '1, '1, '1, '1, '1, '1);
        send_record(pptc_pkg::CMD_PROTOCOL, 64'h5, 16'h0000, '1, 32'h0, 32'h0, 32'h0);
        send_record(pptc_pkg::CMD_PROTOCOL, 64'h6, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                    '1, '1);
        send_record(pptc_pkg::CMD_PROTOCOL, 64'h7, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h0, 32'h0);
        send_record(pptc_pkg::CMD_PROTOCOL, 64'h8, 16'hAAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                    32'h0, 32'h0);
        send_record(pptc_pkg::CMD_COUNTERS, 64'h0, 16'hFFFF, '1, '1, 32'h0, 32'h0);
        send_record(pptc_pkg::CMD_PROTOCOL, 64'h8000_0000_0000_0000, 16'h8000,
                    32'h8000_0000, 32'h8000_0000, '1, '1);
        key_pool.push_back(16'h0000);
        key_pool.push_back(16'hFFFF);
        key_pool.push_back(16'hAAAA);
        key_pool.push_back(16'h5555);
        key_pool.push_back(16'h8000);
        hold_until_drained();

        sent = 0;
        while (sent < RECORD_COUNT)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RECORD_COUNT; b++)
            begin
                cmd = ($urandom_range(0, 3) == 0) ? pptc_pkg::CMD_COUNTERS
                                                  : pptc_pkg::CMD_PROTOCOL;
                if ($urandom_range(0, 1) == 0)
                    key = 16'($urandom_range(0, 65535));
                else
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                if (cmd == pptc_pkg::CMD_PROTOCOL)
                    key_pool.push_back(key);
                send_record(cmd, {$urandom, $urandom}, key, wide_or_small(),
                            wide_or_small(), wide_or_small(), wide_or_small());
                sent++;
                if (sent % DRAIN_EVERY == 0)
                    hold_until_drained();
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 12));
        end

        draining <= 1'b1;
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
